/* rtl/core/poe_pkg.sv */
// ----------------------------------------------------------------------------
// poe_pkg
// Types and constants shared by the prefixed opcode execute block.
// ----------------------------------------------------------------------------
package poe_pkg;

   // input item operations
   typedef enum logic [1:0] {
      OP_EXECUTE     = 2'd0,
      OP_READ_RETURN = 2'd1,
      OP_REG_LOAD    = 2'd2,
      OP_UNUSED      = 2'd3
   } in_op_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_BYTE_WRITE = 2'd0,
      KIND_WORD_WRITE = 2'd1,
      KIND_READ_REQ   = 2'd2,
      KIND_COMPLETE   = 2'd3
   } kind_type;

   // classified commands handed from front to back
   typedef enum logic [2:0] {
      CMD_BRANCH,
      CMD_SWI,
      CMD_ILLEGAL,
      CMD_COMPARE,
      CMD_LOAD,
      CMD_STORE,
      CMD_READ_RETURN,
      CMD_REG_LOAD
   } cmd_op_type;

   // read in flight and what its data is for
   typedef enum logic [2:0] {
      PEND_NONE,
      PEND_CMP_D,
      PEND_CMP_Y,
      PEND_CMP_U,
      PEND_CMP_S,
      PEND_LOAD_Y,
      PEND_LOAD_S,
      PEND_VECTOR
   } pend_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      BK_RUN,
      BK_SWI,
      BK_STORE_TAIL
   } back_state_type;

   // addressing modes from opcode bits 5:4
   localparam logic [1:0] MODE_IMM = 2'd0;
   localparam logic [1:0] MODE_DIR = 2'd1;
   localparam logic [1:0] MODE_IDX = 2'd2;
   localparam logic [1:0] MODE_EXT = 2'd3;

   // 16-bit register codes
   localparam logic [1:0] REG_D = 2'd0;
   localparam logic [1:0] REG_Y = 2'd1;
   localparam logic [1:0] REG_U = 2'd2;
   localparam logic [1:0] REG_S = 2'd3;

   // register load selects
   localparam logic [3:0] SEL_A  = 4'd0;
   localparam logic [3:0] SEL_B  = 4'd1;
   localparam logic [3:0] SEL_X  = 4'd2;
   localparam logic [3:0] SEL_Y  = 4'd3;
   localparam logic [3:0] SEL_U  = 4'd4;
   localparam logic [3:0] SEL_S  = 4'd5;
   localparam logic [3:0] SEL_DP = 4'd6;
   localparam logic [3:0] SEL_PC = 4'd7;
   localparam logic [3:0] SEL_CC = 4'd8;

   localparam logic [15:0] VectorSwi2 = 16'hFFF4;
   localparam logic [15:0] VectorSwi3 = 16'hFFF2;
   localparam logic [4:0]  SwiCycles  = 5'd20;
   localparam logic [3:0]  SwiLastStep = 4'd12;
   localparam int          QueueDepth = 2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic        page;
      logic [7:0]  instruction_byte;
      logic [15:0] operand_word;
      logic [15:0] indexed_address;
      logic [15:0] read_word;
      logic [3:0]  register_select;
      logic [15:0] register_value;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] address;
      logic [15:0] data;
      logic [15:0] program_counter;
      logic [7:0]  condition_codes;
      logic [4:0]  cycles;
      logic        illegal;
      logic        last;
   } rsp_type;

   typedef struct packed {
      cmd_op_type  op;
      logic        page;
      logic [3:0]  cond;
      logic [1:0]  mode;
      logic [1:0]  rsel;
      logic [4:0]  cyc;
      logic [15:0] operand;
      logic [15:0] index_addr;
      logic [15:0] value;
      logic [3:0]  regsel;
   } cmd_type;

   // queue handshake between front and back
   typedef struct packed {
      logic push;
      logic pop;
      logic full;
      logic empty;
   } queue_ctl_type;

endpackage

/* rtl/core/poe_req_intf.sv */
// ----------------------------------------------------------------------------
// poe_req_intf
// Input channel: valid, ready and one instruction item.
// ----------------------------------------------------------------------------
interface poe_req_intf;
   logic              valid;
   logic              ready;
   poe_pkg::req_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/poe_rsp_intf.sv */
// ----------------------------------------------------------------------------
// poe_rsp_intf
// Result channel: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface poe_rsp_intf;
   logic              valid;
   logic              ready;
   poe_pkg::rsp_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/poe_front.sv */
// ----------------------------------------------------------------------------
// poe_front
// Accepts input items and classifies the prefixed opcode into a command.
// ----------------------------------------------------------------------------
module poe_front (
   poe_req_intf.sink         req_chan,
   input  logic              queue_full,
   output logic              push,
   output poe_pkg::cmd_type  cmd
);

   logic [7:0] opb;
   logic [3:0] lo;
   logic [1:0] mode;

   assign opb  = req_chan.payload.instruction_byte;
   assign lo   = opb[3:0];
   assign mode = opb[5:4];

   // accept whenever the queue has room; unused opcodes are dropped
   assign req_chan.ready = !queue_full;
   assign push = req_chan.valid && !queue_full &&
                 (req_chan.payload.opcode != poe_pkg::OP_UNUSED);

   // opcode classification
   always_comb begin
      cmd.op         = poe_pkg::CMD_ILLEGAL;
      cmd.page       = req_chan.payload.page;
      cmd.cond       = lo;
      cmd.mode       = mode;
      cmd.rsel       = poe_pkg::REG_D;
      cmd.cyc        = 5'd0;
      cmd.operand    = req_chan.payload.operand_word;
      cmd.index_addr = req_chan.payload.indexed_address;
      cmd.value      = req_chan.payload.register_value;
      cmd.regsel     = req_chan.payload.register_select;
      case (req_chan.payload.opcode)
         poe_pkg::OP_READ_RETURN: begin
            cmd.op    = poe_pkg::CMD_READ_RETURN;
            cmd.value = req_chan.payload.read_word;
         end
         poe_pkg::OP_REG_LOAD: cmd.op = poe_pkg::CMD_REG_LOAD;
         poe_pkg::OP_EXECUTE: begin
            if (!req_chan.payload.page && opb inside {[8'h21:8'h2F]}) begin
               cmd.op = poe_pkg::CMD_BRANCH;
            end else if (opb == 8'h3F) begin
               cmd.op = poe_pkg::CMD_SWI;
            end else if (opb >= 8'h80) begin
               if (!req_chan.payload.page) begin
                  if (opb < 8'hC0) begin
                     if (lo == 4'h3) begin
                        cmd.op = poe_pkg::CMD_COMPARE; cmd.rsel = poe_pkg::REG_D;
                     end else if (lo == 4'hC) begin
                        cmd.op = poe_pkg::CMD_COMPARE; cmd.rsel = poe_pkg::REG_Y;
                     end else if (lo == 4'hE) begin
                        cmd.op = poe_pkg::CMD_LOAD; cmd.rsel = poe_pkg::REG_Y;
                     end else if (lo == 4'hF && mode != poe_pkg::MODE_IMM) begin
                        cmd.op = poe_pkg::CMD_STORE; cmd.rsel = poe_pkg::REG_Y;
                     end
                  end else begin
                     if (lo == 4'hE) begin
                        cmd.op = poe_pkg::CMD_LOAD; cmd.rsel = poe_pkg::REG_S;
                     end else if (lo == 4'hF && mode != poe_pkg::MODE_IMM) begin
                        cmd.op = poe_pkg::CMD_STORE; cmd.rsel = poe_pkg::REG_S;
                     end
                  end
               end else if (opb < 8'hC0) begin
                  if (lo == 4'h3) begin
                     cmd.op = poe_pkg::CMD_COMPARE; cmd.rsel = poe_pkg::REG_U;
                  end else if (lo == 4'hC) begin
                     cmd.op = poe_pkg::CMD_COMPARE; cmd.rsel = poe_pkg::REG_S;
                  end
               end
            end
            // base cycle counts per addressing mode
            if (cmd.op == poe_pkg::CMD_COMPARE) begin
               case (mode)
                  poe_pkg::MODE_IMM: cmd.cyc = 5'd5;
                  poe_pkg::MODE_DIR: cmd.cyc = 5'd7;
                  poe_pkg::MODE_IDX: cmd.cyc = 5'd7;
                  default:           cmd.cyc = 5'd8;
               endcase
            end else begin
               case (mode)
                  poe_pkg::MODE_IMM: cmd.cyc = 5'd4;
                  poe_pkg::MODE_DIR: cmd.cyc = 5'd6;
                  poe_pkg::MODE_IDX: cmd.cyc = 5'd6;
                  default:           cmd.cyc = 5'd7;
               endcase
            end
         end
         default: cmd.op = poe_pkg::CMD_ILLEGAL;
      endcase
   end

endmodule

/* rtl/core/poe_queue.sv */
// ----------------------------------------------------------------------------
// poe_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module poe_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  poe_pkg::cmd_type       push_cmd,
   input  logic                   pop,
   output poe_pkg::queue_ctl_type ctl,
   output poe_pkg::cmd_type       head
);

   localparam int PtrW = (poe_pkg::QueueDepth > 1) ? $clog2(poe_pkg::QueueDepth) : 1;
   localparam int CntW = $clog2(poe_pkg::QueueDepth + 1);

   poe_pkg::cmd_type  store_ff [poe_pkg::QueueDepth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign ctl.full  = (count_ff == CntW'(poe_pkg::QueueDepth));
   assign ctl.empty = (count_ff == '0);
   assign do_push   = push && !ctl.full;
   assign do_pop    = pop && !ctl.empty;
   assign ctl.push  = do_push;
   assign ctl.pop   = do_pop;
   assign head      = store_ff[rd_ptr_ff];

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(poe_pkg::QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(poe_pkg::QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CntW'(do_push) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/core/poe_back.sv */
// ----------------------------------------------------------------------------
// poe_back
// Register file and sequencer that carries out commands and emits results.
// ----------------------------------------------------------------------------
module poe_back (
   input  logic                   clock,
   input  logic                   reset,
   input  poe_pkg::queue_ctl_type qctl,
   input  poe_pkg::cmd_type       head,
   output logic                   pop,
   poe_rsp_intf.source            rsp_chan
);

   logic [7:0]  a_ff, a_in, b_ff, b_in, dp_ff, dp_in, cc_ff, cc_in;
   logic [15:0] x_ff, x_in, y_ff, y_in, u_ff, u_in, s_ff, s_in, pc_ff, pc_in;
   poe_pkg::pend_type       pend_ff, pend_in;
   logic [4:0]              pcyc_ff, pcyc_in, tail_cyc_ff, tail_cyc_in;
   logic [3:0]              step_ff, step_in;
   logic [15:0]             vec_ff, vec_in;
   poe_pkg::back_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   poe_pkg::rsp_type        rsp_ff, rsp_in;

   logic                    out_free, emit, taken;
   poe_pkg::kind_type       e_kind;
   logic [15:0]             e_addr, e_data, r16, addr, ld_val;
   logic [4:0]              e_cyc;
   logic                    e_ill, e_last;
   logic [7:0]              push_byte;
   logic [1:0]              act_reg;

   // clear V, set N and Z from a 16-bit value
   function automatic logic [7:0] nz16(logic [7:0] f, logic [15:0] v);
      return {f[7:4], v[15], (v == 16'd0), 1'b0, f[0]};
   endfunction

   // flags of a 16-bit compare r - m
   function automatic logic [7:0] cmp16(logic [7:0] f, logic [15:0] r, logic [15:0] m);
      logic [15:0] res;
      logic [7:0]  g;
      res = r - m;
      g   = nz16(f, res);
      return {g[7:2], ((r[15] ^ m[15]) & (r[15] ^ res[15])), (m > r)};
   endfunction

   // long branch conditions
   function automatic logic cond_true(logic [3:0] c, logic [7:0] f);
      logic cf, vf, zf, nf;
      cf = f[0]; vf = f[1]; zf = f[2]; nf = f[3];
      case (c)
         4'h2:    return !(cf || zf);
         4'h3:    return cf || zf;
         4'h4:    return !cf;
         4'h5:    return cf;
         4'h6:    return !zf;
         4'h7:    return zf;
         4'h8:    return !vf;
         4'h9:    return vf;
         4'hA:    return !nf;
         4'hB:    return nf;
         4'hC:    return nf == vf;
         4'hD:    return nf != vf;
         4'hE:    return !zf && (nf == vf);
         4'hF:    return zf || (nf != vf);
         default: return 1'b0;
      endcase
   endfunction

   // 16-bit register read
   function automatic logic [15:0] sel16(logic [1:0] r, logic [15:0] d, logic [15:0] y,
                                         logic [15:0] u, logic [15:0] s);
      case (r)
         poe_pkg::REG_D: return d;
         poe_pkg::REG_Y: return y;
         poe_pkg::REG_U: return u;
         default:        return s;
      endcase
   endfunction

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign pop      = out_free && (state_ff == poe_pkg::BK_RUN) && !qctl.empty;
   assign taken    = cond_true(head.cond, cc_ff);
   assign r16      = sel16(head.rsel, {a_ff, b_ff}, y_ff, u_ff, s_ff);

   // effective address of memory modes
   always_comb begin
      case (head.mode)
         poe_pkg::MODE_DIR: addr = {dp_ff, head.operand[15:8]};
         poe_pkg::MODE_IDX: addr = head.index_addr;
         default:           addr = head.operand;
      endcase
   end

   // byte pushed at each interrupt step
   always_comb begin
      case (step_ff)
         4'd0:    push_byte = pc_ff[7:0];
         4'd1:    push_byte = pc_ff[15:8];
         4'd2:    push_byte = u_ff[7:0];
         4'd3:    push_byte = u_ff[15:8];
         4'd4:    push_byte = y_ff[7:0];
         4'd5:    push_byte = y_ff[15:8];
         4'd6:    push_byte = x_ff[7:0];
         4'd7:    push_byte = x_ff[15:8];
         4'd8:    push_byte = dp_ff;
         4'd9:    push_byte = b_ff;
         4'd10:   push_byte = a_ff;
         default: push_byte = cc_ff;
      endcase
   end

   // register targeted by a pending read
   always_comb begin
      case (pend_ff)
         poe_pkg::PEND_CMP_D:  act_reg = poe_pkg::REG_D;
         poe_pkg::PEND_CMP_Y:  act_reg = poe_pkg::REG_Y;
         poe_pkg::PEND_CMP_U:  act_reg = poe_pkg::REG_U;
         default:              act_reg = poe_pkg::REG_S;
      endcase
   end

   assign ld_val = head.value;

   // sequencer and register file next state
   always_comb begin
      a_in = a_ff; b_in = b_ff; dp_in = dp_ff; cc_in = cc_ff;
      x_in = x_ff; y_in = y_ff; u_in = u_ff; s_in = s_ff; pc_in = pc_ff;
      pend_in     = pend_ff;
      pcyc_in     = pcyc_ff;
      tail_cyc_in = tail_cyc_ff;
      step_in     = step_ff;
      vec_in      = vec_ff;
      state_in    = state_ff;
      emit   = 1'b0;
      e_kind = poe_pkg::KIND_COMPLETE;
      e_addr = 16'd0;
      e_data = 16'd0;
      e_cyc  = 5'd0;
      e_ill  = 1'b0;
      e_last = 1'b1;
      if (out_free) begin
         case (state_ff)
            poe_pkg::BK_SWI: begin
               emit = 1'b1;
               if (step_ff == poe_pkg::SwiLastStep) begin
                  e_kind   = poe_pkg::KIND_READ_REQ;
                  e_addr   = vec_ff;
                  pend_in  = poe_pkg::PEND_VECTOR;
                  pcyc_in  = poe_pkg::SwiCycles;
                  state_in = poe_pkg::BK_RUN;
               end else begin
                  s_in    = s_ff - 16'd1;
                  e_kind  = poe_pkg::KIND_BYTE_WRITE;
                  e_addr  = s_in;
                  e_data  = {8'd0, push_byte};
                  e_last  = 1'b0;
                  step_in = step_ff + 4'd1;
               end
            end
            poe_pkg::BK_STORE_TAIL: begin
               emit     = 1'b1;
               e_cyc    = tail_cyc_ff;
               state_in = poe_pkg::BK_RUN;
            end
            default: begin
               if (!qctl.empty) begin
                  case (head.op)
                     poe_pkg::CMD_BRANCH: begin
                        pend_in = poe_pkg::PEND_NONE;
                        emit    = 1'b1;
                        if (taken) begin
                           pc_in = pc_ff + 16'd2 + head.operand;
                           e_cyc = 5'd6;
                        end else begin
                           pc_in = pc_ff + 16'd2;
                           e_cyc = 5'd5;
                        end
                     end
                     poe_pkg::CMD_SWI: begin
                        pend_in  = poe_pkg::PEND_NONE;
                        cc_in    = cc_ff | 8'h80;
                        vec_in   = head.page ? poe_pkg::VectorSwi3 : poe_pkg::VectorSwi2;
                        step_in  = 4'd0;
                        state_in = poe_pkg::BK_SWI;
                     end
                     poe_pkg::CMD_ILLEGAL: begin
                        pend_in = poe_pkg::PEND_NONE;
                        emit    = 1'b1;
                        e_ill   = 1'b1;
                     end
                     poe_pkg::CMD_COMPARE, poe_pkg::CMD_LOAD, poe_pkg::CMD_STORE: begin
                        pend_in = poe_pkg::PEND_NONE;
                        emit    = 1'b1;
                        if (head.mode == poe_pkg::MODE_IMM) begin
                           pc_in = pc_ff + 16'd2;
                           e_cyc = head.cyc;
                           if (head.op == poe_pkg::CMD_COMPARE) begin
                              cc_in = cmp16(cc_ff, r16, head.operand);
                           end else begin
                              cc_in = nz16(cc_ff, head.operand);
                              if (head.rsel == poe_pkg::REG_Y) y_in = head.operand;
                              else s_in = head.operand;
                           end
                        end else begin
                           pc_in = (head.mode == poe_pkg::MODE_EXT) ? pc_ff + 16'd2
                                                                    : pc_ff + 16'd1;
                           e_addr = addr;
                           if (head.op == poe_pkg::CMD_STORE) begin
                              cc_in       = nz16(cc_ff, r16);
                              e_kind      = poe_pkg::KIND_WORD_WRITE;
                              e_data      = r16;
                              e_last      = 1'b0;
                              tail_cyc_in = head.cyc;
                              state_in    = poe_pkg::BK_STORE_TAIL;
                           end else begin
                              e_kind  = poe_pkg::KIND_READ_REQ;
                              pcyc_in = head.cyc;
                              if (head.op == poe_pkg::CMD_COMPARE) begin
                                 pend_in = poe_pkg::pend_type'(3'(head.rsel) + 3'd1);
                              end else begin
                                 pend_in = (head.rsel == poe_pkg::REG_Y) ?
                                           poe_pkg::PEND_LOAD_Y : poe_pkg::PEND_LOAD_S;
                              end
                           end
                        end
                     end
                     poe_pkg::CMD_READ_RETURN: begin
                        if (pend_ff != poe_pkg::PEND_NONE) begin
                           emit    = 1'b1;
                           e_cyc   = pcyc_ff;
                           pend_in = poe_pkg::PEND_NONE;
                           case (pend_ff)
                              poe_pkg::PEND_LOAD_Y: begin
                                 y_in  = ld_val;
                                 cc_in = nz16(cc_ff, ld_val);
                              end
                              poe_pkg::PEND_LOAD_S: begin
                                 s_in  = ld_val;
                                 cc_in = nz16(cc_ff, ld_val);
                              end
                              poe_pkg::PEND_VECTOR: pc_in = ld_val;
                              default: cc_in = cmp16(cc_ff,
                                 sel16(act_reg, {a_ff, b_ff}, y_ff, u_ff, s_ff), ld_val);
                           endcase
                        end
                     end
                     default: begin
                        // register load
                        emit = 1'b1;
                        case (head.regsel)
                           poe_pkg::SEL_A:  a_in  = ld_val[7:0];
                           poe_pkg::SEL_B:  b_in  = ld_val[7:0];
                           poe_pkg::SEL_X:  x_in  = ld_val;
                           poe_pkg::SEL_Y:  y_in  = ld_val;
                           poe_pkg::SEL_U:  u_in  = ld_val;
                           poe_pkg::SEL_S:  s_in  = ld_val;
                           poe_pkg::SEL_DP: dp_in = ld_val[7:0];
                           poe_pkg::SEL_PC: pc_in = ld_val;
                           poe_pkg::SEL_CC: cc_in = ld_val[7:0];
                           default: ;
                        endcase
                     end
                  endcase
               end
            end
         endcase
      end
   end

   // output register, shows state after the result's effect
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in           = emit;
         rsp_in.kind            = e_kind;
         rsp_in.address         = e_addr;
         rsp_in.data            = e_data;
         rsp_in.program_counter = pc_in;
         rsp_in.condition_codes = cc_in;
         rsp_in.cycles          = e_cyc;
         rsp_in.illegal         = e_ill;
         rsp_in.last            = e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0; b_ff <= '0; dp_ff <= '0; cc_ff <= '0;
         x_ff <= '0; y_ff <= '0; u_ff <= '0; s_ff <= '0; pc_ff <= '0;
         pend_ff      <= poe_pkg::PEND_NONE;
         pcyc_ff      <= '0;
         tail_cyc_ff  <= '0;
         step_ff      <= '0;
         vec_ff       <= '0;
         state_ff     <= poe_pkg::BK_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_ff <= a_in; b_ff <= b_in; dp_ff <= dp_in; cc_ff <= cc_in;
         x_ff <= x_in; y_ff <= y_in; u_ff <= u_in; s_ff <= s_in; pc_ff <= pc_in;
         pend_ff      <= pend_in;
         pcyc_ff      <= pcyc_in;
         tail_cyc_ff  <= tail_cyc_in;
         step_ff      <= step_in;
         vec_ff       <= vec_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule

/* rtl/core/cpu_prefixed_opcode_execute.sv */
// ----------------------------------------------------------------------------
// cpu_prefixed_opcode_execute
// Page 2 / page 3 instruction execution with its own register file.
// ----------------------------------------------------------------------------
// path: an accepted item enters the command queue, its first result the output
// register; throughput: one item per cycle for single-result items while results
// are taken, as the back end emits one result per cycle; stores and SWI2/SWI3
// emit more than one result; the two-entry command queue lets the input side run ahead of stalled results
// reset: synchronous, clears all registers, pending read and queue
module cpu_prefixed_opcode_execute (
   input  logic        clock,
   input  logic        reset,
   poe_req_intf.sink   req_chan,
   poe_rsp_intf.source rsp_chan
);

   poe_pkg::cmd_type       front_cmd, head_cmd;
   poe_pkg::queue_ctl_type qctl;
   logic                   push, pop;

   // decode
   poe_front u_front (
      .req_chan   (req_chan),
      .queue_full (qctl.full),
      .push       (push),
      .cmd        (front_cmd)
   );

   // command queue
   poe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (front_cmd),
      .pop      (pop),
      .ctl      (qctl),
      .head     (head_cmd)
   );

   // execute
   poe_back u_back (
      .clock    (clock),
      .reset    (reset),
      .qctl     (qctl),
      .head     (head_cmd),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

/* rtl/core/poe_checker.sv */
// ----------------------------------------------------------------------------
// poe_checker
// Port-level checks on the result channel of the execute block.
// ----------------------------------------------------------------------------
module poe_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input poe_pkg::rsp_type rsp_payload
);

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // a completion always closes its item
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == poe_pkg::KIND_COMPLETE |-> rsp_payload.last)
      else $error("completion without last");

   // only completions carry cycles or illegal
   a_cyc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind != poe_pkg::KIND_COMPLETE |->
      rsp_payload.cycles == 5'd0 && !rsp_payload.illegal)
      else $error("cycles on a memory result");

   // pushed bytes are bytes and never end an item
   a_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == poe_pkg::KIND_BYTE_WRITE |->
      rsp_payload.data[15:8] == 8'd0 && !rsp_payload.last)
      else $error("bad byte write");

   // nothing shown right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind cpu_prefixed_opcode_execute poe_checker u_poe_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

/* tb/sv/cpu_prefixed_opcode_execute_tb.sv */
// ----------------------------------------------------------------------------
// cpu_prefixed_opcode_execute_tb
// Drives instruction, read-return and register-load items into the prefixed
// opcode execute block and checks every result item against a local model of
// the register file, pending read and instruction decode.
// ----------------------------------------------------------------------------
module cpu_prefixed_opcode_execute_tb;

   logic clock;
   logic reset;
   int   fail_count;

   poe_req_intf req_chan ();
   poe_rsp_intf rsp_chan ();

   cpu_prefixed_opcode_execute dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // clock, period 12
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // model register file
   logic [7:0]         m_a, m_b, m_dp, m_cc;
   logic [15:0]        m_x, m_y, m_u, m_s, m_pc;
   poe_pkg::pend_type  m_pend;
   logic [4:0]         m_pend_cyc;

   poe_pkg::rsp_type result_queue[$];
   poe_pkg::rsp_type typed_rsp[$];

   function automatic logic [15:0] wide_reg(input logic [1:0] r);
      case (r)
         poe_pkg::REG_D: return {m_a, m_b};
         poe_pkg::REG_Y: return m_y;
         poe_pkg::REG_U: return m_u;
         default:        return m_s;
      endcase
   endfunction

   function automatic void set_nz(input logic [15:0] v);
      m_cc = m_cc & 8'hF1;
      if (v[15]) m_cc = m_cc | 8'h08;
      if (v == 16'h0) m_cc = m_cc | 8'h04;
   endfunction

   function automatic void compare16(input logic [15:0] r, input logic [15:0] mv);
      logic [15:0] res;
      res = r - mv;
      set_nz(res);
      m_cc[0] = (mv > r);
      m_cc[1] = (r[15] ^ mv[15]) & (r[15] ^ res[15]);
   endfunction

   function automatic void load16(input logic [1:0] r, input logic [15:0] v);
      if (r == poe_pkg::REG_Y) m_y = v; else m_s = v;
      set_nz(v);
   endfunction

   function automatic bit branch_cond(input logic [3:0] c);
      bit cf, vf, zf, nf;
      cf = m_cc[0]; vf = m_cc[1]; zf = m_cc[2]; nf = m_cc[3];
      case (c)
         4'h2: return !(cf || zf);
         4'h3: return cf || zf;
         4'h4: return !cf;
         4'h5: return cf;
         4'h6: return !zf;
         4'h7: return zf;
         4'h8: return !vf;
         4'h9: return vf;
         4'hA: return !nf;
         4'hB: return nf;
         4'hC: return nf == vf;
         4'hD: return nf != vf;
         4'hE: return !zf && (nf == vf);
         4'hF: return zf || (nf != vf);
         default: return 1'b0;
      endcase
   endfunction

   function automatic void push_result(input poe_pkg::kind_type k, input logic [15:0] ad,
                                       input logic [15:0] dt, input logic [4:0] cy,
                                       input logic il, input logic la);
      poe_pkg::rsp_type r;
      r.kind = k; r.address = ad; r.data = dt; r.program_counter = m_pc;
      r.condition_codes = m_cc; r.cycles = cy; r.illegal = il; r.last = la;
      result_queue.push_back(r);
   endfunction

   function automatic void push_illegal();
      push_result(poe_pkg::KIND_COMPLETE, 16'h0, 16'h0, 5'd0, 1'b1, 1'b1);
   endfunction

   // instruction decode and execute
   function automatic void run_instruction(input poe_pkg::req_type q);
      logic [7:0]  b, bytes [12];
      logic [3:0]  lo;
      logic [1:0]  mode, rg;
      int          op;
      logic [4:0]  cy;
      logic [15:0] ad, v;
      b = q.instruction_byte;
      lo = b[3:0];
      mode = b[5:4];
      op = 0;
      rg = poe_pkg::REG_D;
      m_pend = poe_pkg::PEND_NONE;
      if (!q.page && b >= 8'h21 && b <= 8'h2F) begin
         if (branch_cond(lo)) begin
            m_pc = m_pc + 16'd2 + q.operand_word;
            cy = 5'd6;
         end else begin
            m_pc = m_pc + 16'd2;
            cy = 5'd5;
         end
         push_result(poe_pkg::KIND_COMPLETE, 16'h0, 16'h0, cy, 1'b0, 1'b1);
         return;
      end
      if (b == 8'h3F) begin
         m_cc = m_cc | 8'h80;
         bytes = '{m_pc[7:0], m_pc[15:8], m_u[7:0], m_u[15:8], m_y[7:0], m_y[15:8],
                   m_x[7:0], m_x[15:8], m_dp, m_b, m_a, m_cc};
         for (int i = 0; i < 12; i++) begin
            m_s = m_s - 16'd1;
            push_result(poe_pkg::KIND_BYTE_WRITE, m_s, {8'h0, bytes[i]}, 5'd0, 1'b0,
                        1'b0);
         end
         m_pend = poe_pkg::PEND_VECTOR;
         m_pend_cyc = poe_pkg::SwiCycles;
         push_result(poe_pkg::KIND_READ_REQ,
                     q.page ? poe_pkg::VectorSwi3 : poe_pkg::VectorSwi2, 16'h0, 5'd0,
                     1'b0, 1'b1);
         return;
      end
      if (b < 8'h80) begin
         push_illegal();
         return;
      end
      // op 0 compare, 1 load, 2 store
      if (!q.page) begin
         if (b < 8'hC0) begin
            if (lo == 4'h3) begin op = 0; rg = poe_pkg::REG_D; end
            else if (lo == 4'hC) begin op = 0; rg = poe_pkg::REG_Y; end
            else if (lo == 4'hE) begin op = 1; rg = poe_pkg::REG_Y; end
            else if (lo == 4'hF && mode != poe_pkg::MODE_IMM) begin
               op = 2; rg = poe_pkg::REG_Y;
            end
            else begin push_illegal(); return; end
         end else begin
            if (lo == 4'hE) begin op = 1; rg = poe_pkg::REG_S; end
            else if (lo == 4'hF && mode != poe_pkg::MODE_IMM) begin
               op = 2; rg = poe_pkg::REG_S;
            end
            else begin push_illegal(); return; end
         end
      end else begin
         if (b >= 8'hC0) begin push_illegal(); return; end
         if (lo == 4'h3) begin op = 0; rg = poe_pkg::REG_U; end
         else if (lo == 4'hC) begin op = 0; rg = poe_pkg::REG_S; end
         else begin push_illegal(); return; end
      end
      case (mode)
         poe_pkg::MODE_IMM: cy = (op == 0) ? 5'd5 : 5'd4;
         poe_pkg::MODE_DIR, poe_pkg::MODE_IDX: cy = (op == 0) ? 5'd7 : 5'd6;
         default:  cy = (op == 0) ? 5'd8 : 5'd7;
      endcase
      if (mode == poe_pkg::MODE_IMM) begin
         m_pc = m_pc + 16'd2;
         if (op == 0) compare16(wide_reg(rg), q.operand_word);
         else load16(rg, q.operand_word);
         push_result(poe_pkg::KIND_COMPLETE, 16'h0, 16'h0, cy, 1'b0, 1'b1);
         return;
      end
      if (mode == poe_pkg::MODE_DIR) begin
         ad = {m_dp, q.operand_word[15:8]};
         m_pc = m_pc + 16'd1;
      end else if (mode == poe_pkg::MODE_IDX) begin
         ad = q.indexed_address;
         m_pc = m_pc + 16'd1;
      end else begin
         ad = q.operand_word;
         m_pc = m_pc + 16'd2;
      end
      if (op == 2) begin
         v = wide_reg(rg);
         set_nz(v);
         push_result(poe_pkg::KIND_WORD_WRITE, ad, v, 5'd0, 1'b0, 1'b0);
         push_result(poe_pkg::KIND_COMPLETE, 16'h0, 16'h0, cy, 1'b0, 1'b1);
         return;
      end
      if (op == 0) m_pend = poe_pkg::pend_type'(3'd1 + rg);
      else m_pend = (rg == poe_pkg::REG_Y) ? poe_pkg::PEND_LOAD_Y : poe_pkg::PEND_LOAD_S;
      m_pend_cyc = cy;
      push_result(poe_pkg::KIND_READ_REQ, ad, 16'h0, 5'd0, 1'b0, 1'b1);
   endfunction

   // top-level prediction for one accepted item
   function automatic void predict_item(input poe_pkg::req_type q);
      logic [15:0] v;
      case (poe_pkg::in_op_type'(q.opcode))
         poe_pkg::OP_EXECUTE: run_instruction(q);
         poe_pkg::OP_READ_RETURN: begin
            v = q.read_word;
            if (m_pend != poe_pkg::PEND_NONE) begin
               case (m_pend)
                  poe_pkg::PEND_CMP_D:  compare16(wide_reg(poe_pkg::REG_D), v);
                  poe_pkg::PEND_CMP_Y:  compare16(wide_reg(poe_pkg::REG_Y), v);
                  poe_pkg::PEND_CMP_U:  compare16(wide_reg(poe_pkg::REG_U), v);
                  poe_pkg::PEND_CMP_S:  compare16(wide_reg(poe_pkg::REG_S), v);
                  poe_pkg::PEND_LOAD_Y: load16(poe_pkg::REG_Y, v);
                  poe_pkg::PEND_LOAD_S: load16(poe_pkg::REG_S, v);
                  default: m_pc = v;
               endcase
               m_pend = poe_pkg::PEND_NONE;
               push_result(poe_pkg::KIND_COMPLETE, 16'h0, 16'h0, m_pend_cyc, 1'b0, 1'b1);
            end
         end
         poe_pkg::OP_REG_LOAD: begin
            v = q.register_value;
            case (q.register_select)
               poe_pkg::SEL_A:  m_a = v[7:0];
               poe_pkg::SEL_B:  m_b = v[7:0];
               poe_pkg::SEL_X:  m_x = v;
               poe_pkg::SEL_Y:  m_y = v;
               poe_pkg::SEL_U:  m_u = v;
               poe_pkg::SEL_S:  m_s = v;
               poe_pkg::SEL_DP: m_dp = v[7:0];
               poe_pkg::SEL_PC: m_pc = v;
               poe_pkg::SEL_CC: m_cc = v[7:0];
               default: ;
            endcase
            push_result(poe_pkg::KIND_COMPLETE, 16'h0, 16'h0, 5'd0, 1'b0, 1'b1);
         end
         default: ;
      endcase
   endfunction

   // directed stimulus table
   typedef struct {
      poe_pkg::req_type q;
      bit               typed;
      poe_pkg::rsp_type r;
   } row_type;
   row_type stim_table[$];

   function automatic poe_pkg::req_type mk(input poe_pkg::in_op_type o, input logic pg,
                                           input logic [7:0] ib,
                                           input logic [15:0] ow, input logic [15:0] ia,
                                           input logic [15:0] rw, input logic [3:0] rs,
                                           input logic [15:0] rv);
      poe_pkg::req_type q;
      q.opcode = o; q.page = pg; q.instruction_byte = ib; q.operand_word = ow;
      q.indexed_address = ia; q.read_word = rw; q.register_select = rs;
      q.register_value = rv;
      return q;
   endfunction

   function automatic void add_row(input poe_pkg::req_type q);
      row_type e;
      e.q = q; e.typed = 1'b0; e.r = '0;
      stim_table.push_back(e);
   endfunction

   function automatic void add_typed(input poe_pkg::req_type q, input logic [15:0] pc,
                                     input logic [7:0] cc, input logic [4:0] cy,
                                     input logic il);
      row_type e;
      e.q = q; e.typed = 1'b1;
      e.r.kind = poe_pkg::KIND_COMPLETE; e.r.address = 16'h0; e.r.data = 16'h0;
      e.r.program_counter = pc; e.r.condition_codes = cc; e.r.cycles = cy;
      e.r.illegal = il; e.r.last = 1'b1;
      stim_table.push_back(e);
   endfunction

   function automatic void build_table();
      // right after reset: LBRN-style never taken on 0x21, illegal bytes
      add_typed(mk(poe_pkg::OP_EXECUTE, 1'b0, 8'h21, 16'hFFFF, 16'h0, 16'h0, 4'h0, 16'h0),
                16'h0002, 8'h00, 5'd5, 1'b0);
      add_typed(mk(poe_pkg::OP_EXECUTE, 1'b1, 8'h00, 16'hFFFF, 16'hFFFF, 16'h0, 4'h0,
                   16'h0),
                16'h0002, 8'h00, 5'd0, 1'b1);
      add_typed(mk(poe_pkg::OP_EXECUTE, 1'b0, 8'hC3, 16'h0, 16'h0, 16'h0, 4'h0, 16'h0),
                16'h0002, 8'h00, 5'd0, 1'b1);
      // read return with nothing pending, unused opcode
      add_row(mk(poe_pkg::OP_READ_RETURN, 1'b0, 8'h0, 16'h0, 16'h0, 16'hFFFF, 4'h0,
                 16'h0));
      add_row(mk(poe_pkg::OP_UNUSED, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF,
                 16'hFFFF));
      add_row(mk(poe_pkg::OP_REG_LOAD, 1'b0, 8'h0, 16'h0, 16'h0, 16'h0, poe_pkg::SEL_A,
                 16'hFF80));
      add_row(mk(poe_pkg::OP_REG_LOAD, 1'b0, 8'h0, 16'h0, 16'h0, 16'h0, poe_pkg::SEL_B,
                 16'h0001));
      add_row(mk(poe_pkg::OP_REG_LOAD, 1'b0, 8'h0, 16'h0, 16'h0, 16'h0, poe_pkg::SEL_X,
                 16'hFFFF));
      add_row(mk(poe_pkg::OP_REG_LOAD, 1'b0, 8'h0, 16'h0, 16'h0, 16'h0, poe_pkg::SEL_U,
                 16'h8000));
      add_row(mk(poe_pkg::OP_REG_LOAD, 1'b0, 8'h0, 16'h0, 16'h0, 16'h0, poe_pkg::SEL_DP,
                 16'h00AB));
      add_row(mk(poe_pkg::OP_REG_LOAD, 1'b0, 8'h0, 16'h0, 16'h0, 16'h0, 4'hF, 16'h1234));
      // compare D immediate, overflow case
      add_row(mk(poe_pkg::OP_EXECUTE, 1'b0, 8'h83, 16'h7FFF, 16'h0, 16'h0, 4'h0, 16'h0));
      add_row(mk(poe_pkg::OP_EXECUTE, 1'b0, 8'h2D, 16'h8000, 16'h0, 16'h0, 4'h0, 16'h0));
      // direct load Y, then return the word
      add_row(mk(poe_pkg::OP_EXECUTE, 1'b0, 8'h9E, 16'hCD00, 16'h0, 16'h0, 4'h0, 16'h0));
      add_row(mk(poe_pkg::OP_READ_RETURN, 1'b0, 8'h0, 16'h0, 16'h0, 16'h0000, 4'h0,
                 16'h0));
      // indexed store S, extended compare U (page 3) and its read return
      add_row(mk(poe_pkg::OP_EXECUTE, 1'b0, 8'hEF, 16'h0, 16'hFFFF, 16'h0, 4'h0, 16'h0));
      add_row(mk(poe_pkg::OP_EXECUTE, 1'b1, 8'hB3, 16'hFFFF, 16'h0, 16'h0, 4'h0, 16'h0));
      add_row(mk(poe_pkg::OP_REG_LOAD, 1'b0, 8'h0, 16'h0, 16'h0, 16'h0, poe_pkg::SEL_CC,
                 16'h0050));
      add_row(mk(poe_pkg::OP_READ_RETURN, 1'b0, 8'h0, 16'h0, 16'h0, 16'h8001, 4'h0,
                 16'h0));
      add_row(mk(poe_pkg::OP_EXECUTE, 1'b1, 8'hAC, 16'h0, 16'h1000, 16'h0, 4'h0, 16'h0));
      add_row(mk(poe_pkg::OP_EXECUTE, 1'b0, 8'h3F, 16'h0, 16'h0, 16'h0, 4'h0, 16'h0));
      add_row(mk(poe_pkg::OP_READ_RETURN, 1'b0, 8'h0, 16'h0, 16'h0, 16'hFFFF, 4'h0,
                 16'h0));
      add_row(mk(poe_pkg::OP_EXECUTE, 1'b1, 8'h3F, 16'h0, 16'h0, 16'h0, 4'h0, 16'h0));
      add_row(mk(poe_pkg::OP_READ_RETURN, 1'b0, 8'h0, 16'h0, 16'h0, 16'h2000, 4'h0,
                 16'h0));
      add_row(mk(poe_pkg::OP_REG_LOAD, 1'b0, 8'h0, 16'h0, 16'h0, 16'h0, poe_pkg::SEL_PC,
                 16'hFFFE));
   endfunction

   // random item, biased toward legal instructions and read returns
   function automatic poe_pkg::req_type random_item();
      poe_pkg::req_type q;
      int               pick;
      logic [7:0]       legal2 [12];
      logic [95:0]      raw;
      legal2 = '{8'h83, 8'h8C, 8'h8E, 8'h93, 8'h9C, 8'h9E, 8'h9F, 8'hAF, 8'hBF,
                 8'hCE, 8'hDF, 8'hFE};
      raw = {$urandom, $urandom, $urandom};
      q = raw[$bits(poe_pkg::req_type)-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         q.opcode = poe_pkg::OP_EXECUTE;
         q.page = 1'b0;
         q.instruction_byte = {4'h2, 4'($urandom_range(1, 15))};
      end else if (pick < 55) begin
         q.opcode = poe_pkg::OP_EXECUTE;
         if ($urandom_range(0, 2) == 0) begin
            q.page = 1'b1;
            q.instruction_byte = {2'b10, 2'($urandom), ($urandom_range(0, 1) ? 4'h3 : 4'hC)};
         end else begin
            q.page = 1'b0;
            q.instruction_byte = legal2[$urandom_range(0, 11)];
            q.instruction_byte[5:4] = 2'($urandom);
         end
      end else if (pick < 58) begin
         q.opcode = poe_pkg::OP_EXECUTE;
         q.instruction_byte = 8'h3F;
      end else if (pick < 65) begin
         q.opcode = poe_pkg::OP_EXECUTE;
      end else if (pick < 80) begin
         q.opcode = poe_pkg::OP_READ_RETURN;
      end else if (pick < 97) begin
         q.opcode = poe_pkg::OP_REG_LOAD;
         if ($urandom_range(0, 9) != 0) q.register_select = 4'($urandom_range(0, 8));
      end else begin
         q.opcode = poe_pkg::OP_UNUSED;
      end
      return q;
   endfunction

   // sender
   int     long_hold;
   bit     stim_done;
   bit     pause_done;

   // valid stays up after an accepted item until the next item or a gap
   task automatic send_item(input poe_pkg::req_type q);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= q;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_item(q);
      @(negedge clock);
   endtask

   // receiver: random stalls plus one long hold-off
   initial begin
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold > 0) begin
            rsp_chan.ready <= 1'b0;
            long_hold = long_hold - 1;
         end else if ($urandom_range(0, 19) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(4, 25)) @(negedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         end
         @(negedge clock);
      end
   end

   // result checker
   always @(posedge clock) begin
      poe_pkg::rsp_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (result_queue.size() == 0) begin
            $display("%0t: unexpected result item %h", $time, got);
            fail_count++;
         end else begin
            want = result_queue.pop_front();
            if (typed_rsp.size() > 0 && got.kind == poe_pkg::KIND_COMPLETE) begin
               if (typed_rsp[0] != want) begin
                  $display("%0t: table row mismatch expected %h predicted %h",
                           $time, typed_rsp[0], want);
                  fail_count++;
               end
               void'(typed_rsp.pop_front());
            end
            if (got.kind != want.kind) begin
               $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
               fail_count++;
            end
            if (got.address != want.address) begin
               $display("%0t: address expected %h actual %h", $time, want.address,
                        got.address);
               fail_count++;
            end
            if (got.data != want.data) begin
               $display("%0t: data expected %h actual %h", $time, want.data, got.data);
               fail_count++;
            end
            if (got.program_counter != want.program_counter) begin
               $display("%0t: pc expected %h actual %h", $time, want.program_counter,
                        got.program_counter);
               fail_count++;
            end
            if (got.condition_codes != want.condition_codes) begin
               $display("%0t: cc expected %h actual %h", $time, want.condition_codes,
                        got.condition_codes);
               fail_count++;
            end
            if (got.cycles != want.cycles) begin
               $display("%0t: cycles expected %0d actual %0d", $time, want.cycles,
                        got.cycles);
               fail_count++;
            end
            if (got.illegal != want.illegal) begin
               $display("%0t: illegal expected %b actual %b", $time, want.illegal,
                        got.illegal);
               fail_count++;
            end
            if (got.last != want.last) begin
               $display("%0t: last expected %b actual %b", $time, want.last, got.last);
               fail_count++;
            end
         end
      end
   end

   // main sequence
   initial begin
      poe_pkg::req_type q;
      fail_count = 0;
      long_hold = 0;
      stim_done = 0;
      pause_done = 0;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      m_a = '0; m_b = '0; m_dp = '0; m_cc = '0;
      m_x = '0; m_y = '0; m_u = '0; m_s = '0; m_pc = '0;
      m_pend = poe_pkg::PEND_NONE; m_pend_cyc = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      build_table();
      // the first three rows complete with typed results, checked at their result
      foreach (stim_table[i]) begin
         if (stim_table[i].typed) typed_rsp.push_back(stim_table[i].r);
         send_item(stim_table[i].q);
      end
      for (int n = 0; n < 460; n++) begin
         if (n == 150) long_hold = 80;
         if (n == 300) begin
            req_chan.valid <= 1'b0;
            @(negedge clock);
            while (result_queue.size() != 0) @(negedge clock);
            pause_done = 1;
         end
         q = random_item();
         send_item(q);
      end
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (result_queue.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      stim_done = 1;
      if (fail_count == 0 && result_queue.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // timeout
   initial begin
      #3000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
